/* rtl/pdnp_pkg.sv */
package pdnp_pkg;

  // Coordinate format: signed, COORD_WIDTH bits with FRAC_BITS fraction bits.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int LIMIT_BASE  = 1024;

  // Widths of the distance arithmetic.
  localparam int LIMIT_W = 32;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int MAN_W   = (COORD_WIDTH + 2 > LIMIT_W) ? COORD_WIDTH + 2 : LIMIT_W;
  localparam int ROOT_W  = 32;
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int STEP_W  = $clog2(ROOT_W);

  // Reset value of the search limit, saturated to the register width.
  localparam logic [63:0] LIMIT_WIDE = 64'(LIMIT_BASE) << FRAC_BITS;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET =
    (LIMIT_WIDE > 64'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : LIMIT_W'(LIMIT_WIDE);

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Request kinds.
  localparam logic REQ_POSITION = 1'b0;
  localparam logic REQ_POINT    = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic                          last_point;
  } in_item_t;

  typedef struct packed {
    logic [ROOT_W-1:0] deviation;
    logic              found;
  } out_item_t;

  // One finished scene handed from front to back.
  typedef struct packed {
    logic [ROOT_W-1:0] dx;
    logic [ROOT_W-1:0] dy;
    logic              found;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULX,
    BK_MULY,
    BK_ADD,
    BK_ROOT,
    BK_OUT
  } bk_state_t;

endpackage

/* rtl/pdnp_front.sv */
module pdnp_front import pdnp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  q_status_t          q_stat,
  output logic               push_valid,
  output job_t               push_job
);

  logic [LIMIT_W-1:0]            limit_r;
  logic signed [COORD_WIDTH-1:0] car_x_r, car_y_r;
  logic signed [COORD_WIDTH-1:0] snap_x_r, snap_y_r;
  logic [MAN_W-1:0]              best_man_r;
  logic [DIFF_W-1:0]             best_dx_r, best_dy_r;
  logic                          scene_open_r;
  logic                          hit_r;

  logic                          accept;
  logic signed [COORD_WIDTH-1:0] snap_x_eff, snap_y_eff;
  logic signed [DIFF_W-1:0]      dx_raw, dy_raw;
  logic [DIFF_W-1:0]             adx, ady;
  logic [MAN_W-1:0]              man, best_eff;
  logic [DIFF_W-1:0]             bdx_eff, bdy_eff;
  logic                          hit_eff, take;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;

  // A new scene measures from the current car position and a fresh best.
  assign snap_x_eff = scene_open_r ? snap_x_r : car_x_r;
  assign snap_y_eff = scene_open_r ? snap_y_r : car_y_r;
  assign best_eff   = scene_open_r ? best_man_r : MAN_W'(limit_r);
  assign bdx_eff    = scene_open_r ? best_dx_r : '0;
  assign bdy_eff    = scene_open_r ? best_dy_r : '0;
  assign hit_eff    = scene_open_r && hit_r;

  // Manhattan distance of the incoming point from the snapshot.
  assign dx_raw = DIFF_W'(snap_x_eff) - DIFF_W'(in_data.coord_x);
  assign dy_raw = DIFF_W'(snap_y_eff) - DIFF_W'(in_data.coord_y);
  assign adx    = dx_raw[DIFF_W-1] ? DIFF_W'(-dx_raw) : DIFF_W'(dx_raw);
  assign ady    = dy_raw[DIFF_W-1] ? DIFF_W'(-dy_raw) : DIFF_W'(dy_raw);
  assign man    = MAN_W'(adx) + MAN_W'(ady);
  assign take   = man < best_eff;

  // The scene's last point hands its best offsets to the back end.
  assign push_valid     = accept && (in_data.req_type == REQ_POINT) && in_data.last_point;
  assign push_job.dx    = ROOT_W'(take ? adx : bdx_eff);
  assign push_job.dy    = ROOT_W'(take ? ady : bdy_eff);
  assign push_job.found = hit_eff || take;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= LIMIT_RESET;
      scene_open_r <= 1'b0;
      hit_r        <= 1'b0;
      car_x_r      <= '0;
      car_y_r      <= '0;
      snap_x_r     <= '0;
      snap_y_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (accept) begin
        if (in_data.req_type == REQ_POSITION) begin
          car_x_r <= in_data.coord_x;
          car_y_r <= in_data.coord_y;
        end else begin
          scene_open_r <= !in_data.last_point;
          hit_r        <= hit_eff || take;
          snap_x_r     <= snap_x_eff;
          snap_y_r     <= snap_y_eff;
        end
      end
    end
  end

  // Best point of the open scene.
  always_ff @(posedge clk) begin
    if (accept && (in_data.req_type == REQ_POINT)) begin
      best_man_r <= take ? man : best_eff;
      best_dx_r  <= take ? adx : bdx_eff;
      best_dy_r  <= take ? ady : bdy_eff;
    end
  end

endmodule

/* rtl/pdnp_queue.sv */
module pdnp_queue import pdnp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  job_t      push_job,
  input  logic      pop_ready,
  output job_t      pop_job,
  output q_status_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop_ready && !q_stat.empty;
  assign pop_job      = mem[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/pdnp_back.sv */
module pdnp_back import pdnp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  job_t      pop_job,
  output logic      pop_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  bk_state_t         state_r, state_nxt;
  logic [ROOT_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]   prod_r, n_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [STEP_W-1:0] step_r;
  logic [ROOT_W-1:0] last_dev_r;
  out_item_t         out_r;

  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;
  logic [ROOT_W-1:0] root_nxt;

  // One restoring square root digit per cycle.
  assign rem_sh   = {rem_r[REM_W-3:0], n_r[SQ_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign ge       = rem_sh >= trial;
  assign root_nxt = {root_r[ROOT_W-2:0], ge};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = pop_job.found ? BK_MULX : BK_OUT;
        end
      end
      BK_MULX: state_nxt = BK_MULY;
      BK_MULY: state_nxt = BK_ADD;
      BK_ADD:  state_nxt = BK_ROOT;
      BK_ROOT: begin
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_stall) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pop_ready = (state_r == BK_IDLE);
    out_valid = (state_r == BK_OUT);
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      last_dev_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == BK_ROOT) && (step_r == STEP_W'(ROOT_W - 1))) begin
        last_dev_r <= root_nxt;
      end
    end
  end

  // Datapath: square the offsets, add, then take the root.
  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        dx_r <= pop_job.dx;
        dy_r <= pop_job.dy;
        if (!q_stat.empty && !pop_job.found) begin
          out_r.deviation <= last_dev_r;
          out_r.found     <= 1'b0;
        end
      end
      BK_MULX: prod_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
      BK_MULY: begin
        n_r    <= prod_r;
        prod_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
      end
      BK_ADD: begin
        n_r    <= n_r + prod_r;
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      BK_ROOT: begin
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= root_nxt;
        n_r    <= {n_r[SQ_W-3:0], 2'b00};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          out_r.deviation <= root_nxt;
          out_r.found     <= 1'b1;
        end
      end
      BK_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/path_deviation_nearest_point.sv */
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_item_t: req_type, coord_x, coord_y, last_point
// out_      output     out_valid/out_stall out_item_t: deviation, found
// cfg_      input      cfg_valid/cfg_ready search_limit, 32 bits
//
// Every input transaction is handled in the front; path points are compared
// against the best point one per cycle while in_stall is low. A scene's last point
// queues one job. The back takes the job from the queue, forms the squares and
// their sum, takes the square root one digit per cycle, and presents the result;
// a scene with no qualifying point goes from taking its job straight to the result.
// in_stall rises only while the job queue is full.
// Reset is synchronous and active low; it clears control state and restores the
// default search limit of 1024.0.
module path_deviation_nearest_point import pdnp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  q_status_t q_stat;
  logic      push_valid, pop_ready;
  job_t      push_job, pop_job;

  // Front: position updates, scene tracking and nearest point compare.
  pdnp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  // Queue of finished scenes.
  pdnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .q_stat     (q_stat)
  );

  // Back: Euclidean distance and result register.
  pdnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop_ready (pop_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/pdnp_checker.sv */
module pdnp_checker import pdnp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic [7:0]        pend_r;
  logic [ROOT_W-1:0] seen_dev_r;
  logic              scene_end, out_take;

  assign scene_end = in_valid && !in_stall && (in_data.req_type == REQ_POINT)
                     && in_data.last_point;
  assign out_take  = out_valid && !out_stall;

  // Scenes closed but not yet reported, and the last reported found distance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      seen_dev_r <= '0;
    end else begin
      if (scene_end && !out_take) begin
        pend_r <= pend_r + 1'b1;
      end else if (out_take && !scene_end) begin
        pend_r <= pend_r - 1'b1;
      end
      if (out_take && out_data.found) begin
        seen_dev_r <= out_data.deviation;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_no_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a closed scene");

  a_repeat_dev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.deviation == seen_dev_r)
    else $error("no-hit result does not repeat the previous distance");

endmodule

bind path_deviation_nearest_point pdnp_checker u_chk (.*);

/* bench/path_deviation_nearest_point_tb.sv */
`timescale 1ns / 1ps

module path_deviation_nearest_point_tb import pdnp_pkg::*; ();

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  path_deviation_nearest_point i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predictor state: car position, scene snapshot and the best point so far.
  logic signed [31:0] pos_x, pos_y;
  logic signed [31:0] anchor_x, anchor_y;
  logic signed [31:0] near_x, near_y;
  logic [63:0]        near_dist;
  logic               in_scene;
  logic               near_valid;
  logic [31:0]        held_dev;
  logic [31:0]        cur_limit;

  // Expected results, oldest first.
  out_item_t deviation_q[$];

  int  mismatches;
  int  items_sent;
  int  scenes_closed;
  int  scenes_hit;
  int  limit_writes;
  bit  in_idle_en;
  bit  out_idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #(5_000_000);
    $display("Timeout with %0d results outstanding.", deviation_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Distance along one axis, exact in 64 bits.
  function automatic logic [63:0] axis_gap(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) begin
      d = -d;
    end
    return 64'(d);
  endfunction

  // Floor of the square root, one result bit at a time from the top.
  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_coord(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic in_item_t make_item(logic kind, logic [31:0] x, logic [31:0] y,
                                         logic last);
    in_item_t it;
    it.req_type   = kind;
    it.coord_x    = x;
    it.coord_y    = y;
    it.last_point = last;
    return it;
  endfunction

  // Mostly moderate positions, sometimes anywhere in the coordinate range.
  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(99) < 30) begin
      return $urandom;
    end
    return int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
  endfunction

  // Offset along one axis scaled to the search limit, so that points both
  // qualify and miss.
  function automatic longint rand_offset();
    longint m;
    m = longint'({32'b0, $urandom_range(cur_limit)});
    if ($urandom_range(99) < 25) begin
      m = m >>> $urandom_range(1, 8);
    end
    if ($urandom_range(1) == 1) begin
      m = -m;
    end
    return m;
  endfunction

  // Update the prediction for one accepted transaction.
  function automatic void predict_deviation(in_item_t it);
    logic [63:0] man_dist, dx, dy;
    out_item_t   res;
    if (it.req_type == REQ_POSITION) begin
      pos_x = it.coord_x;
      pos_y = it.coord_y;
      return;
    end
    if (!in_scene) begin
      anchor_x   = pos_x;
      anchor_y   = pos_y;
      near_dist  = {32'b0, cur_limit};
      near_x     = '0;
      near_y     = '0;
      near_valid = 1'b0;
      in_scene   = 1'b1;
    end
    man_dist = axis_gap(anchor_x, it.coord_x) + axis_gap(anchor_y, it.coord_y);
    if (man_dist < near_dist) begin
      near_dist  = man_dist;
      near_x     = it.coord_x;
      near_y     = it.coord_y;
      near_valid = 1'b1;
    end
    if (!it.last_point) begin
      return;
    end
    in_scene = 1'b0;
    scenes_closed++;
    if (near_valid) begin
      dx            = axis_gap(anchor_x, near_x);
      dy            = axis_gap(anchor_y, near_y);
      held_dev      = floor_root(dx * dx + dy * dy);
      res.deviation = held_dev;
      res.found     = 1'b1;
      scenes_hit++;
    end else begin
      res.deviation = held_dev;
      res.found     = 1'b0;
    end
    deviation_q.push_back(res);
  endfunction

  // Send one transaction, with an occasional idle gap in front of it.
  task automatic send_item(in_item_t it);
    if (in_idle_en && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_deviation(it);
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (deviation_q.size() != 0) @(posedge clk);
  endtask

  // Change the search limit once the block has gone quiet.
  task automatic set_search_limit(logic [31:0] v);
    wait_drained();
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  // Result side: random stalls, and a check of every accepted transaction.
  always @(posedge clk) begin
    out_stall <= out_idle_en && ($urandom_range(99) < 32);
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (deviation_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result deviation=%h found=%b", $realtime,
                   out_data.deviation, out_data.found);
        end
      end else begin
        want = deviation_q.pop_front();
        if (out_data.deviation !== want.deviation || out_data.found !== want.found) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: deviation expected %h got %h, found expected %b got %b",
                     $realtime, want.deviation, out_data.deviation, want.found,
                     out_data.found);
          end
        end
      end
    end
  end

  // Scene with no qualifying point right after reset, then a 3-4-5 hit.
  task automatic test_reset_defaults();
    send_item(make_item(REQ_POINT, 32'(2000 << 16), 32'h0, 1'b1));
    send_item(make_item(REQ_POSITION, 32'sh0001_8000, -32'sh0002_4000, 1'b0));
    send_item(make_item(REQ_POINT, 32'(1500 << 16), 32'h0, 1'b0));
    send_item(make_item(REQ_POINT, 32'sh0004_8000, 32'sh0001_C000, 1'b1));
  endtask

  // Equal Manhattan distance: the earlier point must stay.
  task automatic test_tie_keeps_first();
    send_item(make_item(REQ_POSITION, 32'h0, 32'h0, 1'b0));
    send_item(make_item(REQ_POINT, 32'h0003_0000, 32'h0, 1'b0));
    send_item(make_item(REQ_POINT, 32'h0002_0000, 32'h0001_0000, 1'b1));
  endtask

  // The car moves inside a scene; the scene measures from its snapshot.
  task automatic test_update_in_scene();
    send_item(make_item(REQ_POINT, 32'h000A_0000, 32'h0, 1'b0));
    send_item(make_item(REQ_POSITION, 32'(500 << 16), 32'(500 << 16), 1'b0));
    send_item(make_item(REQ_POINT, 32'h0001_0000, 32'h0, 1'b1));
  endtask

  // A last-point flag on a position update gives no result.
  task automatic test_position_last_flag();
    send_item(make_item(REQ_POSITION, -32'sh0007_0000, 32'h0, 1'b1));
    send_item(make_item(REQ_POINT, -32'sh0007_0000, 32'h0, 1'b1));
  endtask

  // Coordinate extremes, a point exactly at the limit, and the limits 0 and 1.
  task automatic test_extremes();
    set_search_limit(32'hFFFF_FFFF);
    send_item(make_item(REQ_POSITION, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_item(make_item(REQ_POINT, 32'h8000_0001, 32'h8000_0000, 1'b1));
    send_item(make_item(REQ_POINT, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_item(make_item(REQ_POSITION, 32'h0, 32'h0, 1'b0));
    send_item(make_item(REQ_POINT, 32'h8000_0001, 32'h7FFF_FFFF, 1'b1));
    set_search_limit(32'h0);
    send_item(make_item(REQ_POINT, 32'h0, 32'h0, 1'b1));
    set_search_limit(32'h1);
    send_item(make_item(REQ_POINT, 32'h0, 32'h0, 1'b1));
  endtask

  // One scene around the car, or now and then a stray transaction.
  task automatic send_scene();
    logic signed [31:0] bx, by, px, py;
    int n;
    if ($urandom_range(99) < 12) begin
      send_item(make_item(1'($urandom_range(1)), $urandom, $urandom,
                          1'($urandom_range(1))));
      return;
    end
    if ($urandom_range(99) < 70) begin
      send_item(make_item(REQ_POSITION, rand_coord(), rand_coord(),
                          $urandom_range(99) < 10));
    end
    bx = in_scene ? anchor_x : pos_x;
    by = in_scene ? anchor_y : pos_y;
    px = bx;
    py = by;
    n  = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(99) < 8) begin
        send_item(make_item(REQ_POSITION, rand_coord(), rand_coord(), 1'b0));
      end
      // A repeated point gives an exact tie.
      if (k == 0 || $urandom_range(99) >= 10) begin
        px = clamp_coord(longint'(bx) + rand_offset());
        py = clamp_coord(longint'(by) + rand_offset());
      end
      send_item(make_item(REQ_POINT, px, py, k == n - 1));
    end
  endtask

  // Close a scene left open by a stray point.
  task automatic close_scene();
    if (in_scene) begin
      send_item(make_item(REQ_POINT, $urandom, $urandom, 1'b1));
    end
  endtask

  task automatic test_random_phase(logic [31:0] lim, int n_items, bit calm, bit pause_mid);
    int  start;
    bit  paused;
    set_search_limit(lim);
    in_idle_en  = !calm;
    out_idle_en = !calm;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < n_items) begin
      send_scene();
      if (pause_mid && !paused && items_sent - start > n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    close_scene();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;

    pos_x      = '0;
    pos_y      = '0;
    anchor_x   = '0;
    anchor_y   = '0;
    near_x     = '0;
    near_y     = '0;
    cur_limit  = LIMIT_RESET;
    near_dist  = {32'b0, LIMIT_RESET};
    in_scene   = 1'b0;
    near_valid = 1'b0;
    held_dev   = '0;

    mismatches    = 0;
    items_sent    = 0;
    scenes_closed = 0;
    scenes_hit    = 0;
    limit_writes  = 0;
    in_idle_en    = 1'b1;
    out_idle_en   = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_tie_keeps_first();
    test_update_in_scene();
    test_position_last_flag();
    test_extremes();

    test_random_phase(LIMIT_RESET, 190, 1'b0, 1'b0);
    test_random_phase(32'hFFFF_FFFF, 190, 1'b0, 1'b1);
    test_random_phase($urandom_range(32'h00FF_FFFF, 1), 190, 1'b0, 1'b0);
    test_random_phase(32'h0, 190, 1'b0, 1'b0);
    test_random_phase($urandom, 190, 1'b1, 1'b0);
    test_random_phase($urandom_range(64, 1), 190, 1'b0, 1'b0);
    test_random_phase(LIMIT_RESET, 190, 1'b0, 1'b0);

    wait_drained();
    repeat (60) @(posedge clk);

    $display("Sent %0d transactions closing %0d scenes, %0d with a qualifying point,",
             items_sent, scenes_closed, scenes_hit);
    $display("across %0d search limit writes including zero and all ones.", limit_writes);
    if (mismatches == 0 && deviation_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, deviation_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
